### design/ipwd_pkg.sv
// Shared types and constants for the IR pulse-width decoder.
package ipwd_pkg;

  localparam int TS_W      = 16;
  localparam int CMD_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_W-1:0] HEADER_MIN_RST = 16'd1800;
  localparam logic [CFG_W-1:0] HEADER_MAX_RST = 16'd3600;
  localparam logic [CFG_W-1:0] ZERO_MIN_RST   = 16'd600;
  localparam logic [CFG_W-1:0] ZERO_MAX_RST   = 16'd2100;
  localparam logic [CFG_W-1:0] ONE_MIN_RST    = 16'd3000;
  localparam logic [CFG_W-1:0] ONE_MAX_RST    = 16'd6600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MIN = 3'd0,
    REG_HEADER_MAX = 3'd1,
    REG_ZERO_MIN   = 3'd2,
    REG_ZERO_MAX   = 3'd3,
    REG_ONE_MIN    = 3'd4,
    REG_ONE_MAX    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] header_min;
    logic [CFG_W-1:0] header_max;
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
    logic [CFG_W-1:0] one_min;
    logic [CFG_W-1:0] one_max;
  } windows_t;

  typedef struct packed {
    logic is_header;
    logic is_zero;
    logic is_one;
  } burst_class_t;

endpackage

### design/ipwd_classify.sv
// Burst width measurement and window classification.
module ipwd_classify
  import ipwd_pkg::*;
(
  input  logic [TS_W-1:0] timestamp,
  input  logic [TS_W-1:0] burst_start,
  input  windows_t        win,
  output burst_class_t    cls
);

  logic [TS_W-1:0] width;

  // wraps modulo 2^16
  assign width = timestamp - burst_start;

  assign cls.is_header = (width > win.header_min) && (width < win.header_max);
  assign cls.is_zero   = (width > win.zero_min)   && (width < win.zero_max);
  assign cls.is_one    = (width > win.one_min)    && (width < win.one_max);

endmodule

### design/ir_pulse_width_decoder.sv
// Top level of the IR pulse-width decoder.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tuser: line_level, tdata: timestamp
//   m_axis    out  m_axis_tvalid/tready      tdata: command
//   cfg       in   cfg_we                    cfg_index, cfg_data
//
// One edge event per cycle, unless a stalled result blocks the input. An event
// is taken into the input register; the classifier and state update then move
// it into the result register. Reset clears control state and restores the
// window registers. A stalled result holds the result register and the input
// register; an empty input register still takes one transaction.
module ir_pulse_width_decoder
  import ipwd_pkg::*;
#(
  parameter int FRAME_BITS = 4  // 1 to 16
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TS_W-1:0]      s_axis_tdata,  // [15:0] timestamp
  input  logic                 s_axis_tuser,  // [0] line_level

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [3:0] command, [7:4] zero

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CntW = $clog2(FRAME_BITS + 1);

  windows_t         win;
  logic             in_valid;
  logic             in_level;
  logic [TS_W-1:0]  in_ts;
  logic             advance;

  logic [TS_W-1:0]  burst_start;
  logic             receiving;
  logic [CntW-1:0]  bits_received;
  logic [CMD_W-1:0] shift_word;
  logic [CMD_W-1:0] command;

  burst_class_t     cls;
  logic [CntW-1:0]  bits_received_next;
  logic [CMD_W-1:0] shift_word_next;
  logic             frame_done;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.header_min <= HEADER_MIN_RST;
      win.header_max <= HEADER_MAX_RST;
      win.zero_min   <= ZERO_MIN_RST;
      win.zero_max   <= ZERO_MAX_RST;
      win.one_min    <= ONE_MIN_RST;
      win.one_max    <= ONE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_MIN: win.header_min <= cfg_data;
        REG_HEADER_MAX: win.header_max <= cfg_data;
        REG_ZERO_MIN:   win.zero_min   <= cfg_data;
        REG_ZERO_MAX:   win.zero_max   <= cfg_data;
        REG_ONE_MIN:    win.one_min    <= cfg_data;
        REG_ONE_MAX:    win.one_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level <= s_axis_tuser;
      in_ts    <= s_axis_tdata;
    end
  end

  ipwd_classify u_classify (
    .timestamp   (in_ts),
    .burst_start (burst_start),
    .win         (win),
    .cls         (cls)
  );

  assign bits_received_next = bits_received + 1'b1;
  assign shift_word_next    = {shift_word[CMD_W-2:0], cls.is_one && !cls.is_zero};
  assign frame_done         = (bits_received_next == CntW'(FRAME_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_start   <= '0;
      receiving     <= 1'b0;
      bits_received <= '0;
      shift_word    <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b0;
      if (in_valid) begin
        if (!in_level) begin
          burst_start <= in_ts;
        end else if (cls.is_header) begin
          receiving     <= 1'b1;
          bits_received <= '0;
          shift_word    <= '0;
        end else if (receiving) begin
          if (cls.is_zero || cls.is_one) begin
            shift_word    <= shift_word_next;
            bits_received <= bits_received_next;
            if (frame_done) begin
              receiving     <= 1'b0;
              m_axis_tvalid <= 1'b1;
            end
          end else begin
            receiving <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command <= shift_word_next;
    end
  end

  assign m_axis_tdata = {{(8 - CMD_W){1'b0}}, command};

endmodule

### design/ipwd_checker.sv
// Port-level checks for the IR pulse-width decoder, bound to the top level.
module ipwd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'd0))
    else $error("padding bits of result not zero");

endmodule

bind ir_pulse_width_decoder ipwd_checker u_ipwd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
